// ===== rtl/core/ipc_pkg.sv =====
package ipc_pkg;

    // Datapath widths of the shared multiply-accumulate unit
    localparam int OPA_W  = 33;
    localparam int OPB_W  = 19;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = 56;

    // Sequencer
    localparam int STEP_W    = 5;
    localparam int LAST_STEP = 21;

    // Fixed-point constants
    localparam int DECAY_Q16 = 150733;   // 2.3 in Q2.16
    localparam int FILT_COEF = 9830;     // 0.15 in Q0.16
    localparam int FILT_KEEP = 55706;    // 1 - 0.15 in Q0.16
    localparam int TWO_G_NUM = 39;       // 2g = 39/2
    localparam int ONE_Q16   = 65536;

    // Round-half-up offsets, loaded into the accumulator on clear
    localparam int ROUND_S8  = 128;
    localparam int ROUND_S13 = 4096;
    localparam int ROUND_S16 = 32768;

    typedef enum logic [3:0] {
        A_NONE,
        A_QA,       // quat_x on the x axis, quat_y on the y axis
        A_QW,
        A_DT,
        A_S,
        A_F,
        A_DYN,
        A_V,
        A_P,
        A_A
    } opa_sel_t;

    typedef enum logic [3:0] {
        B_NONE,
        B_QB,       // quat_z
        B_QD,       // quat_y on the x axis, quat_x on the y axis
        B_DECAY,
        B_TWO_G,
        B_FILT_KEEP,
        B_FILT_COEF,
        B_ONE,
        B_K,
        B_DT,
        B_GD,
        B_GP,
        B_GI
    } opb_sel_t;

    typedef enum logic [1:0] {
        BIAS_ZERO,
        BIAS_S8,
        BIAS_S13,
        BIAS_S16
    } bias_sel_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_S,
        WB_K,
        WB_DYN,
        WB_F,
        WB_V,
        WB_P,
        WB_A,
        WB_OUT
    } wb_sel_t;

    // One step of the per-axis program
    typedef struct packed {
        opa_sel_t  a;
        opb_sel_t  b;
        logic      mac;
        logic      clr;
        logic      neg;
        logic      neg_y;
        bias_sel_t bias;
        wb_sel_t   wb;
    } uop_t;

    // Control word handed to the MAC unit
    typedef struct packed {
        logic      en;
        logic      clr;
        logic      neg;
        bias_sel_t bias;
    } mac_ctrl_t;

    // Per-axis program. A write-back reads the accumulator once the last multiply of
    // its group has passed the product and accumulator registers; the next group may already be issuing.
    function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
        uop_t u;
        u = '{a: A_NONE, b: B_NONE, mac: 1'b0, clr: 1'b0, neg: 1'b0, neg_y: 1'b0,
              bias: BIAS_ZERO, wb: WB_NONE};
        unique case (step)
            // gravity term s = qa*qb +/- qw*qd
            5'd0:  begin u.a = A_QA; u.b = B_QB; u.mac = 1'b1; u.clr = 1'b1; end
            5'd1:  begin u.a = A_QW; u.b = B_QD; u.mac = 1'b1; u.neg_y = 1'b1; end
            // decay factor k
            5'd2:  begin u.a = A_DT; u.b = B_DECAY; u.mac = 1'b1; u.clr = 1'b1;
                         u.bias = BIAS_S16; end
            5'd3:  begin u.wb = WB_S; end
            5'd4:  begin u.wb = WB_K; u.a = A_S; u.b = B_TWO_G; u.mac = 1'b1;
                         u.clr = 1'b1; u.bias = BIAS_S13; end
            // low-pass filter
            5'd5:  begin u.a = A_F; u.b = B_FILT_KEEP; u.mac = 1'b1; u.clr = 1'b1;
                         u.bias = BIAS_S16; end
            5'd6:  begin u.wb = WB_DYN; end
            5'd7:  begin u.a = A_DYN; u.b = B_FILT_COEF; u.mac = 1'b1; end
            // velocity
            5'd8:  begin u.a = A_V; u.b = B_ONE; u.mac = 1'b1; u.clr = 1'b1;
                         u.bias = BIAS_S16; end
            5'd9:  begin u.wb = WB_F; u.a = A_V; u.b = B_K; u.mac = 1'b1;
                         u.neg = 1'b1; end
            5'd10: begin u.a = A_F; u.b = B_DT; u.mac = 1'b1; end
            // position
            5'd11: begin u.a = A_P; u.b = B_ONE; u.mac = 1'b1; u.clr = 1'b1;
                         u.bias = BIAS_S16; end
            5'd12: begin u.wb = WB_V; u.a = A_P; u.b = B_K; u.mac = 1'b1;
                         u.neg = 1'b1; end
            5'd13: begin u.a = A_V; u.b = B_DT; u.mac = 1'b1; end
            // absement
            5'd14: begin u.a = A_A; u.b = B_ONE; u.mac = 1'b1; u.clr = 1'b1;
                         u.bias = BIAS_S16; end
            5'd15: begin u.wb = WB_P; end
            5'd16: begin u.a = A_P; u.b = B_DT; u.mac = 1'b1; end
            // PID sum
            5'd17: begin u.a = A_V; u.b = B_GD; u.mac = 1'b1; u.clr = 1'b1;
                         u.bias = BIAS_S8; end
            5'd18: begin u.wb = WB_A; u.a = A_P; u.b = B_GP; u.mac = 1'b1; end
            5'd19: begin u.a = A_A; u.b = B_GI; u.mac = 1'b1; end
            5'd21: begin u.wb = WB_OUT; end
            default: ;
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/core/ipc_mac.sv =====
module ipc_mac
    import ipc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_ctrl_t               ctrl,
    input  logic signed [OPA_W-1:0] opa,
    input  logic signed [OPB_W-1:0] opb,
    output logic signed [ACC_W-1:0] acc
);

    mac_ctrl_t                 ctrl_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   bias_val;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   base;

    // Stage 1: multiply, control follows the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        if (ctrl_reg.en)
        begin
            acc_reg <= acc_next;
        end
    end

    // Rounding offset on clear
    always_comb
    begin
        unique case (ctrl_reg.bias)
            BIAS_ZERO: bias_val = '0;
            BIAS_S8:   bias_val = ACC_W'(ROUND_S8);
            BIAS_S13:  bias_val = ACC_W'(ROUND_S13);
            BIAS_S16:  bias_val = ACC_W'(ROUND_S16);
            default:   bias_val = '0;
        endcase
    end

    // Stage 2: accumulate
    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        base     = ctrl_reg.clr ? bias_val : acc_reg;
        acc_next = ctrl_reg.neg ? (base - prod_ext) : (base + prod_ext);
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/core/imu_translation_pid_compensator_unit.sv =====
// Each accepted input word goes through two axis passes of 22 steps in the shared
// multiply-accumulate unit, x then y; the result is then loaded into the output
// register once it is free. s_tready is low while an item is in work, so no new
// word is taken before the last result is loaded. A finished result waits in the
// output register while the next word is taken. Reset clears all filter and
// integrator state and loads register defaults (time_step 1311, all gains zero).
module imu_translation_pid_compensator_unit
    import ipc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48],
    //          accel_x[79:64], accel_y[95:80]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,
    // m_tdata: correction_x[31:0], correction_y[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    typedef enum logic [3:0] {
        CFG_TIME_STEP = 4'd0,
        CFG_GAIN_P    = 4'd1,
        CFG_GAIN_I    = 4'd2,
        CFG_GAIN_D    = 4'd3
    } cfg_idx_t;

    // Clamp a 48-bit value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v[47:31] == {17{v[47]}})
        begin
            r = v[31:0];
        end
        else if (v[47])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    state_t                  state_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    axis_reg;

    // Configuration
    logic [15:0]             time_step_reg;
    logic signed [15:0]      gain_p_reg;
    logic signed [15:0]      gain_i_reg;
    logic signed [15:0]      gain_d_reg;

    // Captured sample
    logic signed [15:0]      quat_w_reg;
    logic signed [15:0]      quat_x_reg;
    logic signed [15:0]      quat_y_reg;
    logic signed [15:0]      quat_z_reg;
    logic signed [15:0]      accel_x_reg;
    logic signed [15:0]      accel_y_reg;

    // Intermediates
    logic signed [OPA_W-1:0] s_reg;
    logic signed [OPB_W-1:0] k_reg;
    logic signed [25:0]      dyn_reg;
    logic signed [31:0]      corr_x_reg;
    logic signed [31:0]      corr_y_reg;

    // Per-axis state, index 0 = x, 1 = y
    logic signed [31:0]      filt_reg [2];
    logic signed [31:0]      vel_reg  [2];
    logic signed [31:0]      pos_reg  [2];
    logic signed [31:0]      abs_reg  [2];

    logic                    m_tvalid_reg;
    logic [63:0]             m_tdata_reg;

    uop_t                    uop;
    mac_ctrl_t               mac_ctrl;
    logic signed [OPA_W-1:0] opa;
    logic signed [OPB_W-1:0] opb;
    logic signed [ACC_W-1:0] acc;

    logic signed [31:0]      wb_q16_next;
    logic signed [31:0]      wb_out_next;
    logic signed [25:0]      dyn_next;
    logic signed [15:0]      accel_sel;
    logic signed [24:0]      grav;
    logic                    out_free;
    logic                    s_accept;

    assign uop       = uop_at(step_reg);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // MAC control for the current step
    always_comb
    begin
        mac_ctrl.en   = (state_reg == ST_RUN) && uop.mac;
        mac_ctrl.clr  = uop.clr;
        mac_ctrl.neg  = uop.neg || (uop.neg_y && axis_reg);
        mac_ctrl.bias = uop.bias;
    end

    // Operand A select
    always_comb
    begin
        unique case (uop.a)
            A_QA:    opa = axis_reg ? OPA_W'(quat_y_reg) : OPA_W'(quat_x_reg);
            A_QW:    opa = OPA_W'(quat_w_reg);
            A_DT:    opa = OPA_W'({1'b0, time_step_reg});
            A_S:     opa = s_reg;
            A_F:     opa = OPA_W'(filt_reg[axis_reg]);
            A_DYN:   opa = OPA_W'(dyn_reg);
            A_V:     opa = OPA_W'(vel_reg[axis_reg]);
            A_P:     opa = OPA_W'(pos_reg[axis_reg]);
            A_A:     opa = OPA_W'(abs_reg[axis_reg]);
            default: opa = '0;
        endcase
    end

    // Operand B select
    always_comb
    begin
        unique case (uop.b)
            B_QB:        opb = OPB_W'(quat_z_reg);
            B_QD:        opb = axis_reg ? OPB_W'(quat_x_reg) : OPB_W'(quat_y_reg);
            B_DECAY:     opb = OPB_W'(DECAY_Q16);
            B_TWO_G:     opb = OPB_W'(TWO_G_NUM);
            B_FILT_KEEP: opb = OPB_W'(FILT_KEEP);
            B_FILT_COEF: opb = OPB_W'(FILT_COEF);
            B_ONE:       opb = OPB_W'(ONE_Q16);
            B_K:         opb = k_reg;
            B_DT:        opb = OPB_W'({1'b0, time_step_reg});
            B_GD:        opb = OPB_W'(gain_d_reg);
            B_GP:        opb = OPB_W'(gain_p_reg);
            B_GI:        opb = OPB_W'(gain_i_reg);
            default:     opb = '0;
        endcase
    end

    ipc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .opa   (opa),
        .opb   (opb),
        .acc   (acc)
    );

    // Write-back values; rounding offsets are already in the accumulator
    always_comb
    begin
        wb_q16_next = sat32({{8{acc[ACC_W-1]}}, acc[ACC_W-1:16]});
        wb_out_next = sat32(acc[ACC_W-1:8]);
        grav        = acc[37:13];
        accel_sel   = axis_reg ? accel_y_reg : accel_x_reg;
        dyn_next    = 26'(signed'({accel_sel, 8'd0})) - 26'(grav);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= 16'd1311;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TIME_STEP: time_step_reg <= cfg_data;
                CFG_GAIN_P:    gain_p_reg    <= cfg_data;
                CFG_GAIN_I:    gain_i_reg    <= cfg_data;
                CFG_GAIN_D:    gain_d_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input capture and intermediates
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            quat_w_reg  <= s_tdata[15:0];
            quat_x_reg  <= s_tdata[31:16];
            quat_y_reg  <= s_tdata[47:32];
            quat_z_reg  <= s_tdata[63:48];
            accel_x_reg <= s_tdata[79:64];
            accel_y_reg <= s_tdata[95:80];
        end
        if (state_reg == ST_RUN)
        begin
            unique case (uop.wb)
                WB_S:   s_reg   <= acc[OPA_W-1:0];
                WB_K:   k_reg   <= acc[34:16];
                WB_DYN: dyn_reg <= dyn_next;
                WB_OUT:
                begin
                    if (axis_reg)
                    begin
                        corr_y_reg <= wb_out_next;
                    end
                    else
                    begin
                        corr_x_reg <= wb_out_next;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sequencer, filter and integrator state, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            axis_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            for (int i = 0; i < 2; i++)
            begin
                filt_reg[i] <= '0;
                vel_reg[i]  <= '0;
                pos_reg[i]  <= '0;
                abs_reg[i]  <= '0;
            end
        end
        else
        begin
            // in ST_HOLD the output register is reloaded below
            if (m_tvalid_reg && m_tready && (state_reg != ST_HOLD))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        state_reg <= ST_RUN;
                        step_reg  <= '0;
                        axis_reg  <= 1'b0;
                    end
                end

                ST_RUN:
                begin
                    unique case (uop.wb)
                        WB_F:    filt_reg[axis_reg] <= wb_q16_next;
                        WB_V:    vel_reg[axis_reg]  <= wb_q16_next;
                        WB_P:    pos_reg[axis_reg]  <= wb_q16_next;
                        WB_A:    abs_reg[axis_reg]  <= wb_q16_next;
                        default: ;
                    endcase
                    if (step_reg == STEP_W'(LAST_STEP))
                    begin
                        step_reg <= '0;
                        axis_reg <= !axis_reg;
                        if (axis_reg)
                        begin
                            state_reg <= ST_HOLD;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end

                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {corr_y_reg, corr_x_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
